@@ hw/rtl/lrer_pkg.sv @@
// Package for the layout record element remover: payload structs, codes and defaults.
// Used by lrer_front, lrer_back, the top level and the checker; depends on nothing.
`default_nettype none

package lrer_pkg;

  localparam int unsigned ListDepthDefault = 256;
  localparam int unsigned CountBitsDefault = 24;
  localparam int unsigned JobDepth         = 4;

  localparam logic [7:0] TypeBoundary = 8'h08;
  localparam logic [7:0] TypePath     = 8'h09;
  localparam logic [7:0] TypeEndEl    = 8'h11;

  typedef enum logic [1:0] {
    CMD_BYTE            = 2'd0,
    CMD_APPEND_PATH     = 2'd1,
    CMD_APPEND_BOUNDARY = 2'd2,
    CMD_RESTART         = 2'd3
  } lrer_cmd_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_END   = 2'd1,
    ST_ERROR = 2'd2
  } lrer_status_e;

  typedef enum logic [1:0] {
    PH_SIZE_HI = 2'd0,
    PH_SIZE_LO = 2'd1,
    PH_TYPE    = 2'd2,
    PH_BODY    = 2'd3
  } lrer_phase_e;

  typedef struct packed {
    lrer_cmd_e   cmd;
    logic [7:0]  data_byte;
    logic [23:0] index_value;
  } lrer_in_t;

  typedef struct packed {
    logic [7:0]   out_byte;
    lrer_status_e status;
    logic         last;
  } lrer_out_t;

  // One entry of the job queue: one to three result words.
  typedef struct packed {
    logic [1:0]   cnt;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [7:0]   b2;
    lrer_status_e status;
  } lrer_job_t;

endpackage

`default_nettype wire

@@ hw/rtl/lrer_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module lrer_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/lrer_fifo.sv @@
// Small register queue carrying jobs from the front part to the back part.
// Depends on nothing.
`default_nettype none

module lrer_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   slot_q [Depth];
  logic [PtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrBits'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrBits'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lrer_front.sv @@
// Front part: parses record headers, counts element starts, matches removal lists.
// Depends on lrer_pkg and lrer_ram.
`default_nettype none

module lrer_front #(
  parameter int unsigned ListDepth = lrer_pkg::ListDepthDefault,
  parameter int unsigned CountBits = lrer_pkg::CountBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire lrer_pkg::lrer_in_t item_i,
  output logic                    job_valid_o,
  output lrer_pkg::lrer_job_t     job_o
);

  import lrer_pkg::*;

  localparam int unsigned PtrBits  = $clog2(ListDepth + 1);
  localparam int unsigned AddrBits = (ListDepth > 1) ? $clog2(ListDepth) : 1;

  lrer_phase_e          phase_q, phase_d;
  logic [15:0]          size_q, size_d;
  logic [15:0]          remain_q, remain_d;
  logic                 drop_q, drop_d;
  logic                 end_seen_q, end_seen_d;
  logic                 halt_q, halt_d;
  logic [CountBits-1:0] path_cnt_q, path_cnt_d, bnd_cnt_q, bnd_cnt_d;
  logic [PtrBits-1:0]   path_pos_q, path_pos_d, path_len_q, path_len_d;
  logic [PtrBits-1:0]   bnd_pos_q, bnd_pos_d, bnd_len_q, bnd_len_d;
  logic                 path_byp_q, path_byp_d, bnd_byp_q, bnd_byp_d;
  logic [CountBits-1:0] path_byp_data_q, bnd_byp_data_q;

  logic                 path_we, bnd_we;
  logic [CountBits-1:0] wdata, path_rdata, bnd_rdata, path_head, bnd_head;
  logic [15:0]          body_len, rem_dec;
  logic                 path_hit, bnd_hit, drop_n, end_n, start_body;
  logic                 is_byte, is_type;

  assign wdata     = CountBits'(item_i.index_value);
  assign path_head = path_byp_q ? path_byp_data_q : path_rdata;
  assign bnd_head  = bnd_byp_q ? bnd_byp_data_q : bnd_rdata;
  assign body_len  = (size_q >= 16'd3) ? size_q - 16'd3 : '0;
  assign rem_dec   = (remain_q != '0) ? remain_q - 16'd1 : '0;
  assign path_hit  = (item_i.data_byte == TypePath) && (path_pos_q < path_len_q) &&
                     (path_head == path_cnt_q);
  assign bnd_hit   = (item_i.data_byte == TypeBoundary) && (bnd_pos_q < bnd_len_q) &&
                     (bnd_head == bnd_cnt_q);
  assign is_byte   = accept_i && (item_i.cmd == CMD_BYTE) && !halt_q;
  assign is_type   = is_byte && (phase_q == PH_TYPE);

  lrer_ram #(.Width(CountBits), .Depth(ListDepth)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_len_q[AddrBits-1:0]),
    .wdata_i (wdata),
    .raddr_i (path_pos_d[AddrBits-1:0]),
    .rdata_o (path_rdata)
  );

  lrer_ram #(.Width(CountBits), .Depth(ListDepth)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (bnd_len_q[AddrBits-1:0]),
    .wdata_i (wdata),
    .raddr_i (bnd_pos_d[AddrBits-1:0]),
    .rdata_o (bnd_rdata)
  );

  always_comb begin
    phase_d    = phase_q;
    size_d     = size_q;
    remain_d   = remain_q;
    drop_d     = drop_q;
    end_seen_d = end_seen_q;
    halt_d     = halt_q;
    path_cnt_d = path_cnt_q;
    bnd_cnt_d  = bnd_cnt_q;
    path_pos_d = path_pos_q;
    path_len_d = path_len_q;
    bnd_pos_d  = bnd_pos_q;
    bnd_len_d  = bnd_len_q;
    path_we    = 1'b0;
    bnd_we     = 1'b0;
    drop_n     = drop_q;
    end_n      = end_seen_q;
    start_body = 1'b0;
    if (accept_i) begin
      case (item_i.cmd)
        CMD_APPEND_PATH: begin
          if (path_len_q < PtrBits'(ListDepth)) begin
            path_we    = 1'b1;
            path_len_d = path_len_q + 1'b1;
          end
        end
        CMD_APPEND_BOUNDARY: begin
          if (bnd_len_q < PtrBits'(ListDepth)) begin
            bnd_we    = 1'b1;
            bnd_len_d = bnd_len_q + 1'b1;
          end
        end
        CMD_RESTART: begin
          phase_d    = PH_SIZE_HI;
          size_d     = '0;
          remain_d   = '0;
          drop_d     = 1'b0;
          end_seen_d = 1'b0;
          halt_d     = 1'b0;
          path_cnt_d = '0;
          bnd_cnt_d  = '0;
          path_pos_d = '0;
          path_len_d = '0;
          bnd_pos_d  = '0;
          bnd_len_d  = '0;
        end
        default: begin
          if (!halt_q) begin
            case (phase_q)
              PH_SIZE_HI: begin
                size_d  = {item_i.data_byte, 8'h00};
                phase_d = PH_SIZE_LO;
              end
              PH_SIZE_LO: begin
                size_d  = {size_q[15:8], item_i.data_byte};
                phase_d = PH_TYPE;
              end
              PH_TYPE: begin
                if (size_q == '0) begin
                  halt_d  = 1'b1;
                  phase_d = PH_SIZE_HI;
                end else if (drop_q) begin
                  if (item_i.data_byte == TypeEndEl) begin
                    end_n = 1'b1;
                  end
                  start_body = 1'b1;
                end else begin
                  if (item_i.data_byte == TypePath) begin
                    path_cnt_d = path_cnt_q + 1'b1;
                  end
                  if (item_i.data_byte == TypeBoundary) begin
                    bnd_cnt_d = bnd_cnt_q + 1'b1;
                  end
                  if (path_hit) begin
                    path_pos_d = path_pos_q + 1'b1;
                  end
                  if (bnd_hit) begin
                    bnd_pos_d = bnd_pos_q + 1'b1;
                  end
                  if (path_hit || bnd_hit) begin
                    drop_n = 1'b1;
                    end_n  = 1'b0;
                  end
                  start_body = 1'b1;
                end
                if (start_body) begin
                  if (body_len == '0) begin
                    phase_d = PH_SIZE_HI;
                    if (drop_n && end_n) begin
                      drop_n = 1'b0;
                      end_n  = 1'b0;
                    end
                  end else begin
                    phase_d  = PH_BODY;
                    remain_d = body_len;
                  end
                end
                drop_d     = drop_n;
                end_seen_d = end_n;
              end
              default: begin
                remain_d = rem_dec;
                if (rem_dec == '0) begin
                  phase_d = PH_SIZE_HI;
                  if (drop_q && end_seen_q) begin
                    drop_d     = 1'b0;
                    end_seen_d = 1'b0;
                  end
                end
              end
            endcase
          end
        end
      endcase
    end
    path_byp_d = path_we && (path_len_q == path_pos_d);
    bnd_byp_d  = bnd_we && (bnd_len_q == bnd_pos_d);
  end

  always_comb begin
    job_valid_o  = 1'b0;
    job_o        = '0;
    job_o.cnt    = 2'd1;
    job_o.status = ST_DATA;
    if (is_type) begin
      if (size_q == '0) begin
        job_valid_o  = 1'b1;
        job_o.status = drop_q ? ST_ERROR : ST_END;
      end else if (!drop_q && !path_hit && !bnd_hit) begin
        job_valid_o = 1'b1;
        job_o.cnt   = 2'd3;
        job_o.b0    = size_q[15:8];
        job_o.b1    = size_q[7:0];
        job_o.b2    = item_i.data_byte;
      end
    end else if (is_byte && (phase_q == PH_BODY) && !drop_q) begin
      job_valid_o = 1'b1;
      job_o.b0    = item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIZE_HI;
      size_q     <= '0;
      remain_q   <= '0;
      drop_q     <= 1'b0;
      end_seen_q <= 1'b0;
      halt_q     <= 1'b0;
      path_cnt_q <= '0;
      bnd_cnt_q  <= '0;
      path_pos_q <= '0;
      path_len_q <= '0;
      bnd_pos_q  <= '0;
      bnd_len_q  <= '0;
      path_byp_q <= 1'b0;
      bnd_byp_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      size_q     <= size_d;
      remain_q   <= remain_d;
      drop_q     <= drop_d;
      end_seen_q <= end_seen_d;
      halt_q     <= halt_d;
      path_cnt_q <= path_cnt_d;
      bnd_cnt_q  <= bnd_cnt_d;
      path_pos_q <= path_pos_d;
      path_len_q <= path_len_d;
      bnd_pos_q  <= bnd_pos_d;
      bnd_len_q  <= bnd_len_d;
      path_byp_q <= path_byp_d;
      bnd_byp_q  <= bnd_byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    path_byp_data_q <= wdata;
    bnd_byp_data_q  <= wdata;
  end

endmodule

`default_nettype wire

@@ hw/rtl/lrer_back.sv @@
// Back part: unpacks queued jobs into result words, one word per pop.
// Depends on lrer_pkg.
`default_nettype none

module lrer_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                job_avail_i,
  input  wire lrer_pkg::lrer_job_t job_i,
  output logic                     job_pop_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output lrer_pkg::lrer_out_t      out_o
);

  import lrer_pkg::*;

  lrer_job_t  job_q, job_d;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       at_last, done, load;

  assign at_last   = (idx_q == 2'(job_q.cnt - 2'd1));
  assign done      = valid_q && pop_i && at_last;
  assign load      = job_avail_i && (!valid_q || done);
  assign job_pop_o = load;
  assign empty_o   = !valid_q;

  always_comb begin
    job_d   = job_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      job_d   = job_i;
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (valid_q && pop_i) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    out_o.status = job_q.status;
    out_o.last   = at_last;
    case (idx_q)
      2'd0:    out_o.out_byte = job_q.b0;
      2'd1:    out_o.out_byte = job_q.b1;
      default: out_o.out_byte = job_q.b2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/layout_record_element_remover.sv @@
// Layout record element remover: byte stream filter dropping listed path and boundary
// elements. Depends on lrer_pkg, lrer_front, lrer_fifo and lrer_back.
//
// Usage:
//   Input queue side: drive in_data_i and push; the item is taken at a clock edge with
//   push high and full low. cmd selects a stream byte, an append to the path or boundary
//   removal list (ascending ordinals), or a restart that clears lists and stream state.
//   Result queue side: while empty is low, out_data_o holds the oldest result word; it is
//   taken at an edge with pop high. last marks the final word caused by one input item.
//   With the back stage idle, a taken item's job goes into the job queue register and is
//   then loaded into the back stage, which drives its first result word on out_data_o.
//   Throughput: one input item per cycle unless full, one result word per cycle unless
//   empty. A passed record's type byte yields three words, so the result side sets the
//   rate on header-heavy data; the four-entry front-to-back job queue absorbs this.
//   List reads use one registered RAM port per list, prefetched at the next list position.
//   Reset: empty lists, counters and stream state; no clearing pass, ready at once.
//   Receiver stall: words wait in the back stage and queue; full rises when the queue
//   fills, and stream parsing resumes as soon as a slot frees.
`default_nettype none

module layout_record_element_remover #(
  parameter int unsigned ListDepth = lrer_pkg::ListDepthDefault,
  parameter int unsigned CountBits = lrer_pkg::CountBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire lrer_pkg::lrer_in_t in_data_i,
  output logic                    empty,
  input  wire logic               pop,
  output lrer_pkg::lrer_out_t     out_data_o
);

  import lrer_pkg::*;

  localparam int unsigned JobBits = $bits(lrer_job_t);

  logic               accept;
  logic               job_valid, job_avail, job_pop, fifo_empty;
  lrer_job_t          job_in, job_out;
  logic [JobBits-1:0] fifo_rdata;

  assign accept    = push && !full;
  assign job_avail = !fifo_empty;
  assign job_out   = lrer_job_t'(fifo_rdata);

  lrer_front #(.ListDepth(ListDepth), .CountBits(CountBits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  lrer_fifo #(.Width(JobBits), .Depth(JobDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .rdata_o (fifo_rdata),
    .empty_o (fifo_empty)
  );

  lrer_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (job_avail),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lrer_checker.sv @@
// Port-level checks for the layout record element remover, bound to the top level.
// Depends on lrer_pkg and layout_record_element_remover.
`default_nettype none

module lrer_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                push,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire lrer_pkg::lrer_out_t out_data_o
);

  import lrer_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result word changed while stalled");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_data_o.status != ST_DATA)) |->
      (out_data_o.last && out_data_o.out_byte == 8'h00))
    else $error("status word must be a lone zero word");

  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input item");

  a_burst_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_data_o.last) |=> !empty)
    else $error("word burst broken before its last word");

endmodule

bind layout_record_element_remover lrer_checker u_lrer_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

`default_nettype wire
